// File: rtl/apet_pkg.sv
// Shared constants and types of the acceleration peak and energy tracker.
`timescale 1ns / 1ps
package apet_pkg;

  // Raw axis width taken from each acceleration field (at most the field width of 16).
  localparam int ACCEL_BITS = 16;
  localparam int NUM_LANES  = 3;

  // Fixed-point widths
  localparam int SA_W   = 20;   // scaled acceleration
  localparam int VEL_W  = 48;   // velocity
  localparam int NUM_W  = 64;   // dividend of the velocity increment, padded to whole digits
  localparam int REM_W  = 14;   // remainder of the constant divide
  localparam int DIG_W  = 16;   // dividend digit handled per divide step
  localparam int Q_W    = 49;   // velocity increment
  localparam int MAG_W  = 20;   // acceleration magnitude

  localparam logic signed [23:0] SA_MAX = 24'sd524287;
  localparam logic signed [23:0] SA_MIN = -24'sd524288;
  localparam logic signed [49:0] VEL_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] VEL_MIN = -50'sd140737488355328;

  // Increment = (|s * dt| * 512 + ROUND_K) / DIV_K
  localparam logic [14:0]      DIV_K     = 15'd15625;
  localparam logic [NUM_W-1:0] ROUND_K   = 64'd7812;
  // Digit quotient = ({rem, digit} * RECIP_K) >> RECIP_SH, exact below 2^30
  localparam logic [30:0]      RECIP_K   = 31'd1125899907;
  localparam int               RECIP_SH  = 44;
  // Two divide steps per digit (estimate, then shift), four digits
  localparam logic [3:0]       DIV_STEPS = 4'd8;

  // Configuration register indexes
  typedef enum logic {
    CFG_MASS   = 1'b0,
    CFG_MARGIN = 1'b1
  } cfg_index_t;

  // Commands from the merging stage to one lane
  typedef struct packed {
    logic start;
    logic clear;
  } lane_cmd_t;

  // What one lane reports to the merging stage
  typedef struct packed {
    logic        idle;
    logic        sq_ok;
    logic [39:0] a_sq;
    logic [63:0] c_sq;
  } lane_stat_t;

endpackage

// File: rtl/accel_peak_energy_tracker_unit.sv
// Top level: input channel, axis lanes, magnitude and peak merge, speed and energy, output register.
`timescale 1ns / 1ps
// Acceleration peak and kinetic-energy tracker.
// Input items arrive on s_axis (tdata: acc_x, acc_y, acc_z, timestamp_us) and each
// gives exactly one result item on m_axis (tdata: accel_magnitude, speed,
// energy_change; tuser: is_peak). mass and peak_margin are written through
// cfg_wr_en / cfg_index / cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// One item is worked on at a time. Three axis lanes scale and integrate in
// parallel, each dividing by 15625 one 16-bit digit at a time; the 32-step
// root of the magnitude runs alongside and sets the pace. An item without a
// peak goes from the magnitude straight to the output register; a peak adds
// the velocity clear, the speed root and the energy sequence.
// The result waits in an output register; the next item is taken while it
// waits, and the block stalls only when a new result is ready and the old one
// has not been taken. Synchronous reset clears the control and tracker state,
// sets mass to 256 and peak_margin to 0, and leaves no result pending.
module accel_peak_energy_tracker_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // acc_x[15:0], acc_y[31:16], acc_z[47:32], timestamp_us[79:48]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // accel_magnitude[19:0], speed[51:20], energy_change[115:52]
  output logic         m_axis_tuser,   // is_peak
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_data
);
  import apet_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE, T_SCALE, T_MAG, T_CLR, T_SPD, T_SPW, T_ENW, T_EMIT
  } tstate_t;

  tstate_t                 state;
  logic [15:0]             mass;
  logic [19:0]             margin;
  logic [31:0]             prev_time;
  logic [31:0]             dt;
  logic [MAG_W-1:0]        prev_mag;
  logic [MAG_W-1:0]        last_turn;
  logic                    rising;
  logic                    prev_rising;
  logic [31:0]             last_speed;
  logic signed [63:0]      last_energy;
  logic [MAG_W-1:0]        cur_mag;
  logic                    peak;
  logic [MAG_W-1:0]        o_mag;
  logic                    o_peak;
  logic [31:0]             o_speed;
  logic signed [63:0]      o_energy;
  logic                    o_valid;
  logic                    o_load;

  lane_cmd_t               cmd;
  lane_stat_t              stat [NUM_LANES];
  logic signed [15:0]      acc [NUM_LANES];
  logic                    all_idle;
  logic                    all_sq;
  logic [41:0]             sum_a;
  logic [63:0]             sum_c;
  logic                    sq_start;
  logic [63:0]             sq_din;
  logic                    sq_busy;
  logic [31:0]             sq_root;
  logic                    en_start;
  logic                    en_busy;
  logic signed [63:0]      en_val;
  logic                    accept;
  logic [MAG_W-1:0]        mag_now;
  logic                    rising_next;
  logic [MAG_W-1:0]        swing;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign acc[0] = s_axis_tdata[15:0];
  assign acc[1] = s_axis_tdata[31:16];
  assign acc[2] = s_axis_tdata[47:32];

  assign cmd.start = accept;
  assign cmd.clear = (state == T_CLR);

  // Axis lanes
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    apet_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .acc  (acc[i]),
      .dt   (dt),
      .stat (stat[i])
    );
  end

  // Merge what the lanes report
  always_comb begin
    all_idle = stat[0].idle && stat[1].idle && stat[2].idle;
    all_sq   = stat[0].sq_ok && stat[1].sq_ok && stat[2].sq_ok;
    sum_a    = 42'(stat[0].a_sq) + 42'(stat[1].a_sq) + 42'(stat[2].a_sq);
    sum_c    = stat[0].c_sq + stat[1].c_sq + stat[2].c_sq;
    sq_start = (state == T_SCALE && all_sq) || (state == T_SPD);
    sq_din   = (state == T_SPD) ? sum_c : 64'(sum_a);
    en_start = (state == T_SPW) && !sq_busy;
  end

  apet_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .din   (sq_din),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  apet_energy u_energy (
    .clk       (clk),
    .rst       (rst),
    .start     (en_start),
    .speed_new (sq_root),
    .speed_old (last_speed),
    .mass      (mass),
    .busy      (en_busy),
    .energy    (en_val)
  );

  // Turning-point detector on the new magnitude
  always_comb begin
    mag_now = (sq_root[31:MAG_W] != '0) ? '1 : sq_root[MAG_W-1:0];
    if (prev_mag < mag_now) begin
      rising_next = 1'b1;
    end else if (prev_mag > mag_now) begin
      rising_next = 1'b0;
    end else begin
      rising_next = rising;
    end
    swing = (prev_mag > last_turn) ? prev_mag - last_turn : last_turn - prev_mag;
  end

  assign s_axis_tready = (state == T_IDLE);

  // Load the output register when the merge stage has a result and the slot is free
  assign o_load = (state == T_EMIT) && (!o_valid || m_axis_tready);

  // Control, tracker state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      mass        <= 16'd256;
      margin      <= '0;
      prev_time   <= '0;
      prev_mag    <= '0;
      last_turn   <= '0;
      rising      <= 1'b0;
      prev_rising <= 1'b0;
      last_speed  <= '0;
      last_energy <= '0;
      o_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_MASS:   mass   <= cfg_data[15:0];
          CFG_MARGIN: margin <= cfg_data;
          default:    ;
        endcase
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            dt        <= s_axis_tdata[79:48] - prev_time;
            prev_time <= s_axis_tdata[79:48];
            state     <= T_SCALE;
          end
        end
        T_SCALE: begin
          if (all_sq) begin
            state <= T_MAG;
          end
        end
        T_MAG: begin
          if (!sq_busy && all_idle) begin
            cur_mag  <= mag_now;
            prev_mag <= mag_now;
            rising   <= rising_next;
            peak     <= 1'b0;
            state    <= T_EMIT;
            if (rising_next != prev_rising) begin
              prev_rising <= rising_next;
              last_turn   <= prev_mag;
              if (swing > margin) begin
                peak  <= 1'b1;
                state <= T_CLR;
              end
            end
          end
        end
        T_CLR:  state <= T_SPD;
        T_SPD:  state <= T_SPW;
        T_SPW: begin
          if (!sq_busy) begin
            state <= T_ENW;
          end
        end
        T_ENW: begin
          if (!en_busy && !en_start) begin
            last_speed  <= sq_root;
            last_energy <= en_val;
            state       <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (o_load) begin
            o_mag    <= cur_mag;
            o_peak   <= peak;
            o_speed  <= last_speed;
            o_energy <= last_energy;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_peak;
  assign m_axis_tdata  = {4'd0, o_energy, o_speed, o_mag};

  // Lanes are quiet whenever a new item may enter
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> all_idle)
    else $error("item accepted while a lane is busy");

  // The root unit is never restarted mid-run
  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_busy)
    else $error("root unit started while busy");

  // A result leaving the merge stage is presented next cycle
  a_emit: assert property (@(posedge clk) disable iff (rst)
    o_load |=> m_axis_tvalid)
    else $error("result lost at output register");

  // The energy sequence only runs for a peak result
  a_peak_path: assert property (@(posedge clk) disable iff (rst)
    (state == T_ENW) |-> peak)
    else $error("energy sequence without a peak");

endmodule

// File: rtl/apet_lane.sv
// One axis lane: scale, trapezoid integration with a digit-wise constant divide, squares.
`timescale 1ns / 1ps
module apet_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  apet_pkg::lane_cmd_t     cmd,
  input  logic signed [15:0]      acc,
  input  logic [31:0]             dt,
  output apet_pkg::lane_stat_t    stat
);
  import apet_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_UPD} lstate_t;

  lstate_t                  state;
  logic signed [SA_W-1:0]   a_cur;
  logic signed [SA_W-1:0]   prev_a;
  logic signed [SA_W:0]     s_sum;
  logic signed [53:0]       prod;
  logic [NUM_W-1:0]         num;
  logic [REM_W-1:0]         rem;
  logic [DIG_W-1:0]         q_dig;
  logic [3:0]               cnt;
  logic signed [VEL_W-1:0]  vel;
  logic [39:0]              a_sq;
  logic [63:0]              c_sq;
  logic                     sq_ok;

  logic signed [ACCEL_BITS-1:0] raw;
  logic signed [23:0]       raw_ext;
  logic signed [23:0]       a_x10;
  logic signed [SA_W-1:0]   scaled;
  logic [SA_W-1:0]          a_abs;
  logic [52:0]              prod_abs;
  logic [REM_W+DIG_W-1:0]   x_div;
  logic [60:0]              x_mul;
  logic [DIG_W-1:0]         q_next;
  logic [REM_W+DIG_W-1:0]   q_back;
  logic [REM_W+DIG_W-1:0]   x_left;
  logic [REM_W-1:0]         rem_next;
  logic signed [49:0]       vel_ext;
  logic signed [49:0]       q_ext;
  logic signed [49:0]       nv;
  logic signed [VEL_W-1:0]  vel_next;
  logic [VEL_W-1:0]         vel_abs;
  logic [31:0]              c_val;

  // Scale by ten and saturate
  always_comb begin
    raw     = acc[ACCEL_BITS-1:0];
    raw_ext = 24'(raw);
    a_x10   = (raw_ext <<< 3) + (raw_ext <<< 1);
    if (a_x10 > SA_MAX) begin
      scaled = SA_MAX[SA_W-1:0];
    end else if (a_x10 < SA_MIN) begin
      scaled = SA_MIN[SA_W-1:0];
    end else begin
      scaled = a_x10[SA_W-1:0];
    end
  end

  // Magnitudes, one divide digit and the saturated velocity update
  always_comb begin
    a_abs    = a_cur[SA_W-1] ? SA_W'(-a_cur) : SA_W'(a_cur);
    prod_abs = prod[53] ? 53'(-prod) : 53'(prod);
    x_div    = {rem, num[NUM_W-1 -: DIG_W]};
    x_mul    = 61'(x_div) * 61'(RECIP_K);
    q_next   = x_mul[RECIP_SH +: DIG_W];
    q_back   = (REM_W+DIG_W)'(q_dig) * (REM_W+DIG_W)'(DIV_K);
    x_left   = x_div - q_back;
    rem_next = x_left[REM_W-1:0];
    vel_ext  = 50'(vel);
    q_ext    = signed'({1'b0, num[Q_W-1:0]});
    nv       = prod[53] ? vel_ext - q_ext : vel_ext + q_ext;
    if (nv > VEL_MAX) begin
      vel_next = VEL_MAX[VEL_W-1:0];
    end else if (nv < VEL_MIN) begin
      vel_next = VEL_MIN[VEL_W-1:0];
    end else begin
      vel_next = nv[VEL_W-1:0];
    end
    vel_abs  = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
    c_val    = vel_abs[VEL_W-1:16];
  end

  // Sequence one item through multiply, divide and update
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      prev_a <= '0;
      vel    <= '0;
      sq_ok  <= 1'b0;
      cnt    <= '0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            a_cur  <= scaled;
            s_sum  <= (SA_W+1)'(scaled) + (SA_W+1)'(prev_a);
            prev_a <= scaled;
            sq_ok  <= 1'b0;
            state  <= L_MUL;
          end else if (cmd.clear) begin
            c_sq <= 64'(c_val) * 64'(c_val);
            vel  <= '0;
          end
        end
        L_MUL: begin
          prod  <= 54'(s_sum) * 54'(signed'({1'b0, dt}));
          a_sq  <= 40'(a_abs) * 40'(a_abs);
          sq_ok <= 1'b1;
          cnt   <= '0;
          rem   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          // Load the dividend, then per digit: estimate the quotient, then shift it in
          if (cnt == '0) begin
            num <= NUM_W'({prod_abs, 9'd0}) + ROUND_K;
          end else if (cnt[0]) begin
            q_dig <= q_next;
          end else begin
            num <= {num[NUM_W-DIG_W-1:0], q_dig};
            rem <= rem_next;
          end
          if (cnt == DIV_STEPS) begin
            state <= L_UPD;
          end
          cnt <= cnt + 4'd1;
        end
        L_UPD: begin
          vel   <= vel_next;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign stat.idle  = (state == L_IDLE);
  assign stat.sq_ok = sq_ok;
  assign stat.a_sq  = a_sq;
  assign stat.c_sq  = c_sq;

endmodule

// File: rtl/apet_sqrt.sv
// Shared integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module apet_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output logic        busy,
  output logic [31:0] root
);
  import apet_pkg::*;

  logic [63:0] x;
  logic [34:0] rem;
  logic [4:0]  cnt;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  // One digit of the root
  always_comb begin
    rem_sh = {rem[32:0], x[63:62]};
    trial  = {1'b0, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      x    <= din;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      x    <= {x[61:0], 2'b00};
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[30:0], ge};
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/apet_energy.sv
// Kinetic energy change: squares, difference, mass scaling and saturation on one multiplier.
`timescale 1ns / 1ps
module apet_energy (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        speed_new,
  input  logic [31:0]        speed_old,
  input  logic [15:0]        mass,
  output logic               busy,
  output logic signed [63:0] energy
);
  import apet_pkg::*;

  typedef enum logic [2:0] {E_IDLE, E_SQN, E_SQO, E_DIFF, E_LO, E_HI, E_SUM} estate_t;

  estate_t     state;
  logic [31:0] sp_n;
  logic [31:0] sp_o;
  logic [15:0] m;
  logic [63:0] prod;
  logic [63:0] vn2;
  logic [63:0] d;
  logic        neg;
  logic [47:0] p_lo;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [79:0] total;
  logic [70:0] r;
  logic [70:0] limit;
  logic [63:0] r_sat;

  // Operand selection for the shared multiplier
  always_comb begin
    unique case (state)
      E_SQN:   begin mul_a = sp_n;       mul_b = sp_n; end
      E_SQO:   begin mul_a = sp_o;       mul_b = sp_o; end
      E_LO:    begin mul_a = d[31:0];    mul_b = 32'(m); end
      E_HI:    begin mul_a = d[63:32];   mul_b = 32'(m); end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
    total = {prod[47:0], 32'd0} + 80'(p_lo);
    r     = total[79:9];
    limit = neg ? 71'(64'h8000_0000_0000_0000) : 71'(64'h7FFF_FFFF_FFFF_FFFF);
    r_sat = (r > limit) ? limit[63:0] : r[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      busy  <= 1'b0;
    end else begin
      prod <= 64'(mul_a) * 64'(mul_b);
      unique case (state)
        E_IDLE: begin
          if (start) begin
            sp_n  <= speed_new;
            sp_o  <= speed_old;
            m     <= mass;
            busy  <= 1'b1;
            state <= E_SQN;
          end
        end
        E_SQN:  state <= E_SQO;
        E_SQO: begin
          vn2   <= prod;
          state <= E_DIFF;
        end
        E_DIFF: begin
          neg   <= (vn2 < prod);
          d     <= (vn2 < prod) ? prod - vn2 : vn2 - prod;
          state <= E_LO;
        end
        E_LO:   state <= E_HI;
        E_HI: begin
          p_lo  <= prod[47:0];
          state <= E_SUM;
        end
        E_SUM: begin
          energy <= neg ? signed'(64'(-r_sat)) : signed'(r_sat);
          busy   <= 1'b0;
          state  <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/accel_peak_energy_tracker_unit_test.sv
// Testbench for the acceleration peak and energy tracker: directed, saturation and random tests.
`timescale 1ns / 1ps
module accel_peak_energy_tracker_unit_test;
  import apet_pkg::*;

  typedef struct {
    logic [19:0] mag;
    logic        peak;
    logic [31:0] speed;
    logic [63:0] energy;
  } tracker_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_index = 1'b0;
  logic [19:0]  cfg_data = '0;

  // Predictor state
  logic [31:0]  trk_time;
  longint       trk_vel [3];
  longint       trk_acc [3];
  logic [19:0]  trk_mag, trk_turn;
  logic         trk_rising, trk_rising_old;
  logic [31:0]  trk_speed;
  logic [63:0]  trk_energy;
  logic [15:0]  trk_mass;
  logic [19:0]  trk_margin;

  tracker_result_t pending_results[$];
  int  n_errors = 0, n_results = 0, n_peaks = 0;
  bit  sender_quiet = 0, receiver_quiet = 0;
  int  hold_request = 0;

  accel_peak_energy_tracker_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Integer square root, floor
  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Energy change mass * (new^2 - old^2) / 512, saturated
  function automatic logic [63:0] energy_delta(logic [63:0] vn2, logic [63:0] vo2,
                                               logic [15:0] m);
    logic         neg;
    logic [63:0]  d;
    logic [127:0] p, lim;
    neg = vn2 < vo2;
    d = neg ? vo2 - vn2 : vn2 - vo2;
    p = ({64'd0, d} * {112'd0, m}) >> 9;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
    if (p > lim) p = lim;
    return neg ? (~p[63:0] + 64'd1) : p[63:0];
  endfunction

  task automatic reset_tracker();
    trk_time = 0;
    for (int i = 0; i < 3; i++) begin
      trk_vel[i] = 0;
      trk_acc[i] = 0;
    end
    trk_mag = 0; trk_turn = 0; trk_rising = 0; trk_rising_old = 0;
    trk_speed = 0; trk_energy = 0; trk_mass = 16'd256; trk_margin = 0;
  endtask

  // Advance the tracker by one sample and queue its result
  task automatic track_sample(logic [15:0] raw [3], logic [31:0] ts);
    longint          a, s, prod, magp, q, nv;
    logic [31:0]     dt;
    logic [63:0]     sq, r, vs, c, sp;
    logic [19:0]     cur, diff;
    bit              peak;
    tracker_result_t res;
    dt = ts - trk_time;
    trk_time = ts;
    sq = 0;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      a = longint'($signed(raw[i])) * 10;
      if (a > 524287) a = 524287;
      if (a < -524288) a = -524288;
      s = a + trk_acc[i];
      prod = s * longint'({32'd0, dt});
      magp = prod < 0 ? -prod : prod;
      q = (magp * 512 + 7812) / 15625;
      nv = prod < 0 ? trk_vel[i] - q : trk_vel[i] + q;
      if (nv > 64'sd140737488355327) nv = 64'sd140737488355327;
      if (nv < -64'sd140737488355328) nv = -64'sd140737488355328;
      trk_vel[i] = nv;
      trk_acc[i] = a;
      magp = a < 0 ? -a : a;
      sq = sq + magp * magp;
    end
    r = root_floor(sq);
    cur = r > 64'd1048575 ? 20'hFFFFF : r[19:0];
    // Track direction; equal magnitudes keep it
    if (trk_mag < cur) trk_rising = 1;
    else if (trk_mag > cur) trk_rising = 0;
    if (trk_rising != trk_rising_old) begin
      trk_rising_old = trk_rising;
      diff = trk_mag > trk_turn ? trk_mag - trk_turn : trk_turn - trk_mag;
      if (diff > trk_margin) peak = 1;
      trk_turn = trk_mag;
    end
    trk_mag = cur;
    if (peak) begin
      vs = 0;
      for (int i = 0; i < 3; i++) begin
        c = (trk_vel[i] < 0 ? -trk_vel[i] : trk_vel[i]) >> 16;
        vs = vs + c * c;
        trk_vel[i] = 0;
      end
      sp = root_floor(vs);
      if (sp > 64'hFFFF_FFFF) sp = 64'hFFFF_FFFF;
      trk_energy = energy_delta(sp * sp, {32'd0, trk_speed} * {32'd0, trk_speed}, trk_mass);
      trk_speed = sp[31:0];
    end
    res.mag = cur; res.peak = peak; res.speed = trk_speed; res.energy = trk_energy;
    pending_results.push_back(res);
  endtask

  // Offer one item and wait for its acceptance
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [31:0] ts);
    int gap;
    logic [15:0] raw [3];
    gap = sender_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ts, z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    raw[0] = x; raw[1] = y; raw[2] = z;
    track_sample(raw, ts);
  endtask

  // Wait until every result is back and the block has settled
  task automatic drain();
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [19:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MASS) trk_mass = val[15:0];
    else trk_margin = val;
  endtask

  // Receiver: random stalls, with an occasional long hold-off
  initial begin
    int stall;
    forever begin
      stall = receiver_quiet ? 0 : $urandom_range(0, 13);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    tracker_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item mag=%0d", $time, m_axis_tdata[19:0]);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        n_results++;
        if (m_axis_tuser) n_peaks++;
        if (m_axis_tdata[19:0] !== e.mag) begin
          $display("%0t: accel_magnitude expected %0d actual %0d", $time, e.mag,
                   m_axis_tdata[19:0]);
          n_errors++;
        end
        if (m_axis_tuser !== e.peak) begin
          $display("%0t: is_peak expected %0d actual %0d", $time, e.peak, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[51:20] !== e.speed) begin
          $display("%0t: speed expected %0d actual %0d", $time, e.speed, m_axis_tdata[51:20]);
          n_errors++;
        end
        if (m_axis_tdata[115:52] !== e.energy) begin
          $display("%0t: energy_change expected %0d actual %0d", $time, $signed(e.energy),
                   $signed(m_axis_tdata[115:52]));
          n_errors++;
        end
      end
    end
  end

  // Extremes, first sample, timestamp wrap, equal magnitudes
  task automatic test_directed();
    send_sample(16'h0000, 16'h0000, 16'h0000, 32'd1000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd2000);
    send_sample(16'h8000, 16'h8000, 16'h8000, 32'd3000);
    send_sample(16'h0000, 16'h0000, 16'h0000, 32'd4000);
    send_sample(16'h7FFF, 16'h8000, 16'h0001, 32'd5000);
    send_sample(16'hFFFF, 16'h0000, 16'h0000, 32'd6000);
    send_sample(16'hFFFF, 16'h0000, 16'h0000, 32'd7000);
    send_sample(16'h0800, 16'h0000, 16'h0000, 32'hFFFF_FFF0);
    send_sample(16'h1000, 16'hF000, 16'h0800, 32'h0000_0010);
    send_sample(16'h1000, 16'hF000, 16'h0800, 32'h0000_0010);
    send_sample(16'h0100, 16'h0100, 16'h0100, 32'h0000_4000);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_5555);
    send_sample(16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    drain();
  endtask

  // Saturate velocity and energy both ways, then a zero mass
  task automatic test_saturation();
    logic [31:0] ts;
    write_reg(CFG_MARGIN, 20'hFFFFF);
    write_reg(CFG_MASS, 20'h0FFFF);
    ts = 32'd100;
    for (int i = 0; i < 4; i++) begin
      ts = ts - 32'd1;
      send_sample(16'h7FFF, 16'h8000, 16'h7FFF, ts);
    end
    drain();
    write_reg(CFG_MARGIN, 20'd0);
    send_sample(16'h0000, 16'h0000, 16'h0000, ts + 32'd10);
    send_sample(16'h0100, 16'h0000, 16'h0000, ts + 32'd20);
    send_sample(16'h0001, 16'h0000, 16'h0000, ts + 32'd30);
    send_sample(16'h0100, 16'h0000, 16'h0000, ts + 32'd40);
    send_sample(16'h0001, 16'h0000, 16'h0000, ts + 32'd50);
    drain();
    write_reg(CFG_MASS, 20'd0);
    for (int i = 0; i < 4; i++)
      send_sample(16'(i * 3000), 16'h0000, 16'h0000, ts + 32'(1000 * (i + 6)));
    drain();
  endtask

  // Random phases: mostly smooth motion, some noise, varied settings and pacing
  task automatic test_random();
    int cx, cy, cz;
    logic [31:0] ts;
    logic [15:0] margins [4];
    margins[0] = 0; margins[1] = 50; margins[2] = 3000; margins[3] = 16'hFFFF;
    cx = 0; cy = 0; cz = 2048;
    ts = trk_time;
    for (int phase = 0; phase < 17; phase++) begin
      write_reg(CFG_MASS, phase == 0 ? 20'h0FFFF : 20'($urandom_range(0, 65535)));
      write_reg(CFG_MARGIN, phase == 1 ? 20'hFFFFF :
                            (phase % 5 == 0 ? 20'($urandom) : 20'(margins[phase % 4])));
      sender_quiet = (phase % 4 == 3);
      receiver_quiet = (phase % 6 == 5);
      if (phase == 7) hold_request = 400;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          ts = $urandom_range(0, 7) == 0 ? $urandom : ts + $urandom_range(0, 5000);
          send_sample(16'($urandom), 16'($urandom), 16'($urandom), ts);
        end else begin
          cx = cx + int'($urandom_range(0, 4000)) - 2000;
          cy = cy + int'($urandom_range(0, 4000)) - 2000;
          cz = cz + int'($urandom_range(0, 4000)) - 2000;
          if (cx > 32767) cx = 32767; if (cx < -32768) cx = -32768;
          if (cy > 32767) cy = 32767; if (cy < -32768) cy = -32768;
          if (cz > 32767) cz = 32767; if (cz < -32768) cz = -32768;
          ts = ts + $urandom_range(500, 2000);
          send_sample(16'(cx), 16'(cy), 16'(cz), ts);
        end
      end
      drain();
    end
  endtask

  initial begin
    reset_tracker();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_random();
    sender_quiet = 0;
    receiver_quiet = 0;
    $display("Checked %0d result items, %0d of them peaks, over directed, saturation",
             n_results, n_peaks);
    $display("and random motion tests with varied mass, margin and flow control.");
    if (n_errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Give up after a generous limit
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
